// ===== rtl/gn2d_pkg.sv =====
// Shared types and constants for the 2D gradient noise evaluator.
// Depends on nothing; every other file in rtl uses it by scoped names.
package gn2d_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_EVAL  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Configuration port geometry and register indexes (paddr[2]).
  localparam int   CFG_AW          = 3;
  localparam int   CFG_DW          = 32;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;
  localparam int   SIZE_W          = 7;
  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

  // Fixed field widths of the request and result words.
  localparam int CELL_W    = 6;
  localparam int FRAC_IN_W = 8;
  localparam int GRAD_W    = 7;
  localparam int NOISE_W   = 16;

  // Width used to compare cell indexes against grid sizes up to 256.
  localparam int IDX_W = 9;

  // Corner numbering for the four gradient reads.
  localparam int NCORNER = 4;
  localparam int C00     = 0;
  localparam int C10     = 1;
  localparam int C01     = 2;
  localparam int C11     = 3;

  // Saturation limits of the result.
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7FFF;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

  // One stored gradient vector.
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } grad_t;

  // Control group from the pipeline to the gradient store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

// ===== rtl/gn2d_if.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on gn2d_pkg for field widths.
interface gn2d_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [gn2d_pkg::CELL_W-1:0]         cell_x;
  logic [gn2d_pkg::CELL_W-1:0]         cell_y;
  logic [gn2d_pkg::FRAC_IN_W-1:0]      frac_x;
  logic [gn2d_pkg::FRAC_IN_W-1:0]      frac_y;
  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_x;
  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_y;

  modport source (output valid, req_type, cell_x, cell_y, frac_x, frac_y, grad_x, grad_y,
                  input ready);
  modport sink   (input valid, req_type, cell_x, cell_y, frac_x, frac_y, grad_x, grad_y,
                  output ready);
endinterface

interface gn2d_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [gn2d_pkg::NOISE_W-1:0] noise_value;
  logic                                index_error;

  modport source (output valid, noise_value, index_error, input ready);
  modport sink   (input valid, noise_value, index_error, output ready);
endinterface

// ===== rtl/gn2d_grad_mem.sv =====
// Gradient store: four identical copies, one per corner, so that all
// four corners are read in the same cycle. Depends on gn2d_pkg.
module gn2d_grad_mem #(
  parameter int AW = 12
) (
  input  logic                    clk,
  input  gn2d_pkg::mem_ctrl_t     ctrl,
  input  logic [AW-1:0]           wr_addr,
  input  gn2d_pkg::grad_t         wr_data,
  input  logic [AW-1:0]           rd_addr [gn2d_pkg::NCORNER],
  output gn2d_pkg::grad_t         rd_data [gn2d_pkg::NCORNER]
);

  // Every copy takes every write; each copy serves one corner read.
  for (genvar i = 0; i < gn2d_pkg::NCORNER; i++) begin : g_copy
    gn2d_pkg::grad_t mem [2**AW];

    always_ff @(posedge clk) begin
      if (ctrl.wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
        rd_data[i] <= mem[rd_addr[i]];
      end
    end
  end

endmodule

// ===== rtl/gradient_noise_2d_eval.sv =====
// Top level of the 2D gradient noise evaluator: APB registers, pipeline.
// Depends on gn2d_pkg, gn2d_if.sv and gn2d_grad_mem.
//
//   channel  direction  handshake           word
//   req      in         req.valid/ready     req_type, cell, frac, grad
//   res      out        res.valid/ready     noise_value, index_error
//   cfg      in         APB psel/penable    grid_width, grid_height
//
// One word is accepted per cycle while res is not stalled; an eval request passes
// through the eight register stages of the datapath to its result; a write gives none.
// A gradient write is held in stage 1 and lands in the store as it leaves stage 1.
// Reset clears the valid bits and returns both grid sizes to 64; the store is not cleared.
// Each stage holds while the one after it is full and stalled, so a stall
// on res back-pressures req without losing or repeating a word.
module gradient_noise_2d_eval #(
  parameter int MAX_GRID  = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  gn2d_req_if.sink                       req,
  gn2d_res_if.source                     res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gn2d_pkg::CFG_AW-1:0]    paddr,
  input  logic [gn2d_pkg::CFG_DW-1:0]    pwdata,
  output logic [gn2d_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);

  localparam int F  = FRAC_BITS;
  localparam int CW = $clog2(MAX_GRID);
  localparam int AW = 2 * CW;
  localparam int DW = F + 9;          // corner dot product
  localparam int IW = DW + F + 1;     // lerp along x, Q.2F
  localparam int VW = IW + F;         // lerp along y, Q.3F
  localparam int SH = 3 * F - 8;      // shift down to Q.8
  localparam int RW = VW - SH;
  localparam int NW = 3 * F + 2;      // fade numerator
  localparam int GW = gn2d_pkg::GRAD_W;
  localparam int XW = gn2d_pkg::IDX_W;

  localparam logic [XW-1:0]       GRID_MAX = XW'(MAX_GRID);
  localparam logic signed [F+1:0] ONE_S    = (F+2)'(2**F);
  localparam logic [F:0]          ONE_U    = (F+1)'(2**F);

  // Fade 3f^2-2f^3 from precomputed f^2 and f^3, floored and clamped.
  function automatic logic [F:0] fade(input logic [2*F-1:0] f2, input logic [3*F-1:0] f3);
    logic [NW-1:0] num;
    logic [NW-1:0] sub;
    logic [NW-1:0] q;
    num = (NW'(f2) << F) + (NW'(f2) << (F + 1));
    sub = NW'(f3) << 1;
    q   = (sub >= num) ? '0 : ((num - sub) >> (2 * F));
    return (q > NW'(ONE_U)) ? ONE_U : q[F:0];
  endfunction

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [gn2d_pkg::SIZE_W-1:0] grid_width;
  logic [gn2d_pkg::SIZE_W-1:0] grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gn2d_pkg::GRID_SIZE_RESET;
      grid_height <= gn2d_pkg::GRID_SIZE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        gn2d_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[gn2d_pkg::SIZE_W-1:0];
        gn2d_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[gn2d_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = {{(gn2d_pkg::CFG_DW - gn2d_pkg::SIZE_W){1'b0}},
                   (paddr[2] == gn2d_pkg::REG_GRID_HEIGHT) ? grid_height : grid_width};

  // Sizes in use: zero acts as one, anything above the table as the table.
  logic [XW-1:0] w_eff;
  logic [XW-1:0] h_eff;

  assign w_eff = (grid_width == '0) ? XW'(1) :
                 ((XW'(grid_width) > GRID_MAX) ? GRID_MAX : XW'(grid_width));
  assign h_eff = (grid_height == '0) ? XW'(1) :
                 ((XW'(grid_height) > GRID_MAX) ? GRID_MAX : XW'(grid_height));

  // ------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its word moves on.
  // ------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6, v7, out_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

  assign rdy8 = !out_valid || res.ready;
  assign rdy7 = !v7 || rdy8;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req.ready = rdy1;

  // ------------------------------------------------------------------
  // Stage 1: request register.
  // ------------------------------------------------------------------
  logic                          s1_type;
  logic [gn2d_pkg::CELL_W-1:0]   s1_cx;
  logic [gn2d_pkg::CELL_W-1:0]   s1_cy;
  logic [F-1:0]                  s1_fx;
  logic [F-1:0]                  s1_fy;
  logic signed [GW-1:0]          s1_gx;
  logic signed [GW-1:0]          s1_gy;
  logic [15:0]                   fx_pad;
  logic [15:0]                   fy_pad;

  assign fx_pad = {8'b0, req.frac_x};
  assign fy_pad = {8'b0, req.frac_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_type <= req.req_type;
      s1_cx   <= req.cell_x;
      s1_cy   <= req.cell_y;
      s1_fx   <= fx_pad[F-1:0];
      s1_fy   <= fy_pad[F-1:0];
      s1_gx   <= req.grad_x;
      s1_gy   <= req.grad_y;
    end
  end

  // Range check, wrapped neighbours and store addresses.
  logic [XW-1:0]               px0, py0, px1, py1;
  logic [gn2d_pkg::CELL_W:0]   cx_inc, cy_inc;
  logic [gn2d_pkg::CELL_W-1:0] s1_cx1, s1_cy1;
  logic                        s1_err;
  logic                        s1_wr_ok;
  logic [2*F-1:0]              s1_f2x, s1_f2y;

  assign cx_inc   = {1'b0, s1_cx} + 1'b1;
  assign cy_inc   = {1'b0, s1_cy} + 1'b1;
  assign s1_cx1   = (XW'(cx_inc) == w_eff) ? '0 : cx_inc[gn2d_pkg::CELL_W-1:0];
  assign s1_cy1   = (XW'(cy_inc) == h_eff) ? '0 : cy_inc[gn2d_pkg::CELL_W-1:0];
  assign px0      = XW'(s1_cx);
  assign py0      = XW'(s1_cy);
  assign px1      = XW'(s1_cx1);
  assign py1      = XW'(s1_cy1);
  assign s1_err   = (px0 >= w_eff) || (py0 >= h_eff);
  assign s1_wr_ok = (px0 < GRID_MAX) && (py0 < GRID_MAX);
  assign s1_f2x   = s1_fx * s1_fx;
  assign s1_f2y   = s1_fy * s1_fy;

  gn2d_pkg::mem_ctrl_t mem_ctrl;
  logic [AW-1:0]       rd_addr [gn2d_pkg::NCORNER];
  gn2d_pkg::grad_t     g [gn2d_pkg::NCORNER];
  gn2d_pkg::grad_t     wr_data;

  assign mem_ctrl.wr_en = v1 && (s1_type == gn2d_pkg::REQ_WRITE) && s1_wr_ok && rdy2;
  assign mem_ctrl.rd_en = rdy2;
  assign wr_data.gx     = s1_gx;
  assign wr_data.gy     = s1_gy;
  assign rd_addr[gn2d_pkg::C00] = {py0[CW-1:0], px0[CW-1:0]};
  assign rd_addr[gn2d_pkg::C10] = {py0[CW-1:0], px1[CW-1:0]};
  assign rd_addr[gn2d_pkg::C01] = {py1[CW-1:0], px0[CW-1:0]};
  assign rd_addr[gn2d_pkg::C11] = {py1[CW-1:0], px1[CW-1:0]};

  gn2d_grad_mem #(
    .AW (AW)
  ) u_mem (
    .clk     (clk),
    .ctrl    (mem_ctrl),
    .wr_addr (rd_addr[gn2d_pkg::C00]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (g)
  );

  // ------------------------------------------------------------------
  // Stage 2: corner gradients arrive; fraction squares held.
  // ------------------------------------------------------------------
  logic [F-1:0]   s2_fx, s2_fy;
  logic [2*F-1:0] s2_f2x, s2_f2y;
  logic           s2_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1 && (s1_type == gn2d_pkg::REQ_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_fx  <= s1_fx;
      s2_fy  <= s1_fy;
      s2_f2x <= s1_f2x;
      s2_f2y <= s1_f2y;
      s2_err <= s1_err;
    end
  end

  // Offsets from each corner to the point, and the four dot products.
  logic signed [F+1:0] ox0, ox1, oy0, oy1;
  logic signed [DW-1:0] d00, d10, d01, d11;
  logic [3*F-1:0]       s2_f3x, s2_f3y;

  assign ox0 = -$signed({2'b0, s2_fx});
  assign oy0 = -$signed({2'b0, s2_fy});
  assign ox1 = ONE_S - $signed({2'b0, s2_fx});
  assign oy1 = ONE_S - $signed({2'b0, s2_fy});
  assign d00 = g[gn2d_pkg::C00].gx * ox0 + g[gn2d_pkg::C00].gy * oy0;
  assign d10 = g[gn2d_pkg::C10].gx * ox1 + g[gn2d_pkg::C10].gy * oy0;
  assign d01 = g[gn2d_pkg::C01].gx * ox0 + g[gn2d_pkg::C01].gy * oy1;
  assign d11 = g[gn2d_pkg::C11].gx * ox1 + g[gn2d_pkg::C11].gy * oy1;
  assign s2_f3x = s2_f2x * s2_fx;
  assign s2_f3y = s2_f2y * s2_fy;

  // ------------------------------------------------------------------
  // Stage 3: dot products and fraction cubes.
  // ------------------------------------------------------------------
  logic signed [DW-1:0] s3_d00, s3_d10, s3_d01, s3_d11;
  logic [2*F-1:0]       s3_f2x, s3_f2y;
  logic [3*F-1:0]       s3_f3x, s3_f3y;
  logic                 s3_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_d00 <= d00;
      s3_d10 <= d10;
      s3_d01 <= d01;
      s3_d11 <= d11;
      s3_f2x <= s2_f2x;
      s3_f2y <= s2_f2y;
      s3_f3x <= s2_f3x;
      s3_f3y <= s2_f3y;
      s3_err <= s2_err;
    end
  end

  // Fade weights and corner differences along x.
  logic [F:0]         s3_sx, s3_sy;
  logic signed [DW:0] s3_dx0, s3_dx1;

  assign s3_sx  = fade(s3_f2x, s3_f3x);
  assign s3_sy  = fade(s3_f2y, s3_f3y);
  assign s3_dx0 = s3_d10 - s3_d00;
  assign s3_dx1 = s3_d11 - s3_d01;

  // ------------------------------------------------------------------
  // Stage 4: weights ready; lerp along x.
  // ------------------------------------------------------------------
  logic signed [DW-1:0] s4_d00, s4_d01;
  logic signed [DW:0]   s4_dx0, s4_dx1;
  logic [F:0]           s4_sx, s4_sy;
  logic                 s4_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_d00 <= s3_d00;
      s4_d01 <= s3_d01;
      s4_dx0 <= s3_dx0;
      s4_dx1 <= s3_dx1;
      s4_sx  <= s3_sx;
      s4_sy  <= s3_sy;
      s4_err <= s3_err;
    end
  end

  logic signed [IW-1:0] ix0, ix1;
  logic signed [IW-1:0] d00_w, d01_w;

  assign d00_w = IW'(s4_d00);
  assign d01_w = IW'(s4_d01);
  assign ix0   = (d00_w <<< F) + s4_dx0 * $signed({1'b0, s4_sx});
  assign ix1   = (d01_w <<< F) + s4_dx1 * $signed({1'b0, s4_sx});

  // ------------------------------------------------------------------
  // Stage 5: row lerps; difference along y.
  // ------------------------------------------------------------------
  logic signed [IW-1:0] s5_ix0, s5_ix1;
  logic [F:0]           s5_sy;
  logic                 s5_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_ix0 <= ix0;
      s5_ix1 <= ix1;
      s5_sy  <= s4_sy;
      s5_err <= s4_err;
    end
  end

  logic signed [IW:0] idiff;

  assign idiff = s5_ix1 - s5_ix0;

  // ------------------------------------------------------------------
  // Stage 6: lerp along y.
  // ------------------------------------------------------------------
  logic signed [IW-1:0] s6_ix0;
  logic signed [IW:0]   s6_idiff;
  logic [F:0]           s6_sy;
  logic                 s6_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_ix0   <= s5_ix0;
      s6_idiff <= idiff;
      s6_sy    <= s5_sy;
      s6_err   <= s5_err;
    end
  end

  logic signed [VW-1:0] vsum;
  logic signed [VW-1:0] ix0_w;

  assign ix0_w = VW'(s6_ix0);
  assign vsum  = (ix0_w <<< F) + s6_idiff * $signed({1'b0, s6_sy});

  // ------------------------------------------------------------------
  // Stage 7: floor to Q.8 and saturate.
  // ------------------------------------------------------------------
  logic signed [VW-1:0] s7_v;
  logic                 s7_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (rdy7) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_v   <= vsum;
      s7_err <= s6_err;
    end
  end

  logic signed [RW-1:0]                r_q8;
  logic signed [gn2d_pkg::NOISE_W-1:0] r_sat;

  assign r_q8  = $signed(s7_v[VW-1:SH]);
  assign r_sat = (r_q8 > RW'(gn2d_pkg::NOISE_MAX)) ? gn2d_pkg::NOISE_MAX :
                 (r_q8 < RW'(gn2d_pkg::NOISE_MIN)) ? gn2d_pkg::NOISE_MIN :
                 r_q8[gn2d_pkg::NOISE_W-1:0];

  // ------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------
  logic signed [gn2d_pkg::NOISE_W-1:0] out_noise;
  logic                                out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy8) begin
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy8) begin
      out_noise <= s7_err ? '0 : r_sat;
      out_err   <= s7_err;
    end
  end

  assign res.valid       = out_valid;
  assign res.noise_value = out_noise;
  assign res.index_error = out_err;

endmodule

// ===== rtl/gn2d_checker.sv =====
// Port-level checks for the gradient noise evaluator, bound to its top.
// Depends on gn2d_pkg and on the port list of gradient_noise_2d_eval.
module gn2d_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                res_valid,
  input logic                                res_ready,
  input logic signed [gn2d_pkg::NOISE_W-1:0] noise_value,
  input logic                                index_error,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [gn2d_pkg::CFG_AW-1:0]         paddr,
  input logic [gn2d_pkg::CFG_DW-1:0]         pwdata,
  input logic [gn2d_pkg::CFG_DW-1:0]         prdata,
  input logic                                pready
);

  // No result word is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered straight after reset");

  // A stalled result word holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(noise_value) && $stable(index_error))
    else $error("stalled result word changed");

  // An out-of-grid result carries zero noise.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && index_error |-> noise_value == '0)
    else $error("index error with non-zero noise");

  // A written grid size reads back on the next cycle at the same register.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready) ##1 (paddr[2] == $past(paddr[2]))
    |-> prdata == {{(gn2d_pkg::CFG_DW - gn2d_pkg::SIZE_W){1'b0}},
                   $past(pwdata[gn2d_pkg::SIZE_W-1:0])})
    else $error("grid size read-back mismatch");

endmodule

bind gradient_noise_2d_eval gn2d_checker u_gn2d_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .noise_value (res.noise_value),
  .index_error (res.index_error),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);
